### sv/csc_pkg.sv
package csc_pkg;

  localparam int BATCH_LIMIT = 64;
  localparam int SIZE_AW     = $clog2(BATCH_LIMIT);
  localparam int BATCH_W     = $clog2(BATCH_LIMIT + 1);
  localparam int CNT_W       = 7;
  localparam int WORD_W      = 32;
  localparam int PLACE_W     = 31;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_DATA_W  = 40;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NNZ_TOTAL   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BATCH_START = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BATCH_ORDER = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BATCH_END   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ROW_START   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ROW_ORDER   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_ROW_END     = 3'd6;
  localparam logic [STATUS_W-1:0] ST_COL_RANGE   = 3'd7;

  typedef enum logic [2:0] {
    PH_BATCH = 3'b001,
    PH_ROW   = 3'b010,
    PH_COL   = 3'b100
  } phase_t;

endpackage

### sv/csr_structure_checker.sv
// The result transaction is registered and presented in the cycle after the final input
// transaction of a structure is accepted; all other inputs produce no result.
// Throughput: one input transaction per cycle, limited only by the result register
// when a result is not taken; the batch size memory is read every cycle.
// Reset (rst_n, synchronous, active low) clears the stream state and the configuration
// to batch_count 1, other registers 0. The batch size memory is not cleared.
module csr_structure_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream. tdata: word [31:0].
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [csc_pkg::WORD_W-1:0]          in_tdata,
  // Result stream. tdata: status [2:0], where [33:3], zero fill [39:34].
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [csc_pkg::OUT_DATA_W-1:0]      out_tdata,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [csc_pkg::WORD_W-1:0]          cfg_data
);
  import csc_pkg::*;

  // Configuration registers.
  logic [CNT_W-1:0]   batch_count_r;
  logic [PLACE_W-1:0] row_count_r;
  logic [WORD_W-1:0]  col_count_r;
  logic [PLACE_W-1:0] nnz_total_r;

  // Stream state.
  phase_t             phase_r, phase_nxt;
  logic [WORD_W-1:0]  prev_r, prev_nxt;
  logic [BATCH_W-1:0] batch_idx_r, batch_idx_nxt;
  logic [PLACE_W-1:0] row_idx_r, row_idx_nxt;
  logic [PLACE_W-1:0] entry_idx_r, entry_idx_nxt;
  logic [STATUS_W-1:0] err_code_r, err_code_nxt;
  logic [PLACE_W-1:0] err_place_r, err_place_nxt;

  // Result register.
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [PLACE_W-1:0]  out_where_r;

  // Batch size memory: written during the batch pointer section, read at the
  // end of each batch's row pointers.
  logic [WORD_W-1:0]  sizes_mem [BATCH_LIMIT];
  logic [WORD_W-1:0]  size_rd_r;
  logic               mem_we;
  logic [SIZE_AW-1:0] mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [SIZE_AW-1:0] mem_raddr;

  logic               in_fire;
  logic               done;
  logic [BATCH_W-1:0] bc;
  logic signed [WORD_W-1:0] w, p;
  logic               order_bad;
  logic [STATUS_W-1:0] hit_code;
  logic [PLACE_W-1:0] hit_place;
  logic [WORD_W:0]    entry_next;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - STATUS_W - PLACE_W){1'b0}}, out_where_r, out_status_r};

  assign w = in_tdata;
  assign p = prev_r;
  // A pointer pair is out of order when the earlier one is negative or the later is smaller.
  assign order_bad  = (p < 0) || (w < p);
  assign entry_next = {2'b00, entry_idx_r} + 1'b1;

  // Batch count in use, saturated at the memory depth.
  always_comb begin
    if (batch_count_r > CNT_W'(BATCH_LIMIT)) begin
      bc = BATCH_W'(BATCH_LIMIT);
    end else begin
      bc = BATCH_W'(batch_count_r);
    end
  end

  // Violation found by the current word, in the order the rules are checked.
  always_comb begin
    hit_code  = ST_OK;
    hit_place = '0;
    unique case (phase_r)
      PH_BATCH: begin
        priority if (batch_idx_r == '0 && w != 0) begin
          hit_code = ST_BATCH_START;
        end else if (batch_idx_r != '0 && order_bad) begin
          hit_code  = ST_BATCH_ORDER;
          hit_place = PLACE_W'(batch_idx_r - 1'b1);
        end else if (batch_idx_r >= bc && w != $signed({1'b0, nnz_total_r})) begin
          hit_code  = ST_BATCH_END;
          hit_place = PLACE_W'(bc);
        end else begin
          hit_code = ST_OK;
        end
      end
      PH_ROW: begin
        priority if (row_idx_r == '0 && w != 0) begin
          hit_code  = ST_ROW_START;
          hit_place = PLACE_W'(batch_idx_r);
        end else if (row_idx_r != '0 && order_bad) begin
          hit_code  = ST_ROW_ORDER;
          hit_place = PLACE_W'(batch_idx_r);
        end else if (row_idx_r >= row_count_r && in_tdata != size_rd_r) begin
          hit_code  = ST_ROW_END;
          hit_place = PLACE_W'(batch_idx_r);
        end else begin
          hit_code = ST_OK;
        end
      end
      PH_COL: begin
        if (w < 0 || in_tdata >= col_count_r) begin
          hit_code  = ST_COL_RANGE;
          hit_place = entry_idx_r;
        end
      end
      default: begin
        hit_code = ST_OK;
      end
    endcase
  end

  // Stream sequencing and the memory write.
  always_comb begin
    phase_nxt     = phase_r;
    prev_nxt      = prev_r;
    batch_idx_nxt = batch_idx_r;
    row_idx_nxt   = row_idx_r;
    entry_idx_nxt = entry_idx_r;
    err_code_nxt  = err_code_r;
    err_place_nxt = err_place_r;
    done          = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = SIZE_AW'(batch_idx_r - 1'b1);
    mem_wdata     = in_tdata - prev_r;

    if (in_fire) begin
      prev_nxt = in_tdata;
      if (err_code_r == ST_OK) begin
        err_code_nxt  = hit_code;
        err_place_nxt = hit_place;
      end
      unique case (phase_r)
        PH_BATCH: begin
          mem_we = (batch_idx_r != '0);
          if (batch_idx_r >= bc) begin
            if (bc == '0) begin
              if (nnz_total_r == '0) begin
                done = 1'b1;
              end else begin
                phase_nxt     = PH_COL;
                entry_idx_nxt = '0;
              end
            end else begin
              phase_nxt     = PH_ROW;
              batch_idx_nxt = '0;
              row_idx_nxt   = '0;
            end
          end else begin
            batch_idx_nxt = batch_idx_r + 1'b1;
          end
        end
        PH_ROW: begin
          if (row_idx_r >= row_count_r) begin
            if (batch_idx_r + 1'b1 >= bc) begin
              if (nnz_total_r == '0) begin
                done = 1'b1;
              end else begin
                phase_nxt     = PH_COL;
                entry_idx_nxt = '0;
              end
            end else begin
              batch_idx_nxt = batch_idx_r + 1'b1;
              row_idx_nxt   = '0;
            end
          end else begin
            row_idx_nxt = row_idx_r + 1'b1;
          end
        end
        PH_COL: begin
          if (entry_next >= {2'b00, nnz_total_r}) begin
            done = 1'b1;
          end else begin
            entry_idx_nxt = entry_next[PLACE_W-1:0];
          end
        end
        default: begin
          phase_nxt = PH_BATCH;
        end
      endcase
      if (done) begin
        phase_nxt     = PH_BATCH;
        prev_nxt      = '0;
        batch_idx_nxt = '0;
        row_idx_nxt   = '0;
        entry_idx_nxt = '0;
        err_code_nxt  = ST_OK;
        err_place_nxt = '0;
      end
    end
  end

  // The memory is read at the batch index of the next cycle, so the size of the
  // current batch is always waiting in size_rd_r when its last row pointer arrives.
  assign mem_raddr = batch_idx_nxt[SIZE_AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sizes_mem[mem_waddr] <= mem_wdata;
    end
    // Forward a write to the entry being read in the same cycle.
    if (mem_we && mem_waddr == mem_raddr) begin
      size_rd_r <= mem_wdata;
    end else begin
      size_rd_r <= sizes_mem[mem_raddr];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_count_r <= CNT_W'(1);
      row_count_r   <= '0;
      col_count_r   <= '0;
      nnz_total_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BATCH_COUNT: batch_count_r <= cfg_data[CNT_W-1:0];
        REG_ROW_COUNT:   row_count_r   <= cfg_data[PLACE_W-1:0];
        REG_COL_COUNT:   col_count_r   <= cfg_data;
        REG_NNZ_TOTAL:   nnz_total_r   <= cfg_data[PLACE_W-1:0];
        default: begin
          batch_count_r <= batch_count_r;
        end
      endcase
    end
  end

  // Stream state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_BATCH;
      prev_r      <= '0;
      batch_idx_r <= '0;
      row_idx_r   <= '0;
      entry_idx_r <= '0;
      err_code_r  <= ST_OK;
      err_place_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      prev_r      <= prev_nxt;
      batch_idx_r <= batch_idx_nxt;
      row_idx_r   <= row_idx_nxt;
      entry_idx_r <= entry_idx_nxt;
      err_code_r  <= err_code_nxt;
      err_place_r <= err_place_nxt;
    end
  end

  // Result register. The final word's own violation counts if none came earlier.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && done) begin
      if (err_code_r == ST_OK) begin
        out_status_r <= hit_code;
        out_where_r  <= hit_place;
      end else begin
        out_status_r <= err_code_r;
        out_where_r  <= err_place_r;
      end
    end
  end

endmodule
